// File: design/stpq_pkg.sv
`default_nettype none
package stpq_pkg;

  // Operation codes on the cmd field
  localparam logic CMD_ENQ = 1'b0;
  localparam logic CMD_DEQ = 1'b1;

  typedef enum logic [1:0] {
    STAT_ENQ   = 2'd0,
    STAT_DEQ   = 2'd1,
    STAT_FULL  = 2'd2,
    STAT_EMPTY = 2'd3
  } stpq_status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_WALK,
    S_CMP,
    S_DEQ,
    S_RESP
  } stpq_state_t;

  typedef struct packed {
    logic        cmd;
    logic [15:0] item_time;
    logic [7:0]  item_info;
  } stpq_in_t;

  typedef struct packed {
    logic [15:0]  out_time;
    logic [7:0]   out_info;
    stpq_status_t status;
    logic [4:0]   count;
  } stpq_res_t;

endpackage
`default_nettype wire

// File: design/sorted_time_priority_queue_top.sv
`default_nettype none
// Channel     Handshake               Payload
// ---------   ---------------------   -------------------------------
// command     start, busy             item (cmd, item_time, item_info)
// result      done                    result (out_time, out_info, status, count)
// config      cfg_we                  cfg_data (capacity)
//
// A transaction is accepted when start is high and busy is low; busy stays high
// until the result cycle has passed. A dequeue goes through S_DEQ to S_RESP; a
// rejected item goes straight to S_RESP. An enqueue walks from the tail toward
// the head: each move is one read and one compare-and-write through the single
// entry RAM. Reset (rst, synchronous) empties the queue and sets capacity to
// DEPTH, at most 16. done marks one result cycle; the receiver cannot stall it.
module sorted_time_priority_queue_top #(
  parameter int DEPTH     = 16,
  parameter int TIME_BITS = 16
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  output logic                    busy,
  input  wire stpq_pkg::stpq_in_t item,
  output logic                    done,
  output stpq_pkg::stpq_res_t     result,
  input  wire logic               cfg_we,
  input  wire logic [4:0]         cfg_data
);
  import stpq_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int EW = TIME_BITS + 8;

  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [EW-1:0] mem_wdata;
  logic [AW-1:0] mem_raddr;
  logic [EW-1:0] mem_rdata;

  // Sequencer with the shared key compare
  stpq_ctrl #(
    .DEPTH     (DEPTH),
    .TIME_BITS (TIME_BITS)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .item      (item),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .done      (done),
    .result    (result),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  // Entry store
  stpq_mem #(
    .DEPTH (DEPTH),
    .WIDTH (EW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

endmodule
`default_nettype wire

// File: design/stpq_mem.sv
`default_nettype none
module stpq_mem #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 24
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// File: design/stpq_ctrl.sv
`default_nettype none
module stpq_ctrl #(
  parameter int DEPTH     = 16,
  parameter int TIME_BITS = 16
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         start,
  output logic                              busy,
  input  wire stpq_pkg::stpq_in_t           item,
  input  wire logic                         cfg_we,
  input  wire logic [4:0]                   cfg_data,
  output logic                              done,
  output stpq_pkg::stpq_res_t               result,
  output logic                              mem_we,
  output logic [$clog2(DEPTH)-1:0]          mem_waddr,
  output logic [TIME_BITS+7:0]              mem_wdata,
  output logic [$clog2(DEPTH)-1:0]          mem_raddr,
  input  wire logic [TIME_BITS+7:0]         mem_rdata
);
  import stpq_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int PW = $clog2(DEPTH + 1);
  localparam logic [31:0] DEPTH32 = 32'(DEPTH);
  localparam logic [PW-1:0] CAP_RESET = (DEPTH > 16) ? PW'(16) : PW'(DEPTH);

  stpq_state_t state, state_next;

  logic [TIME_BITS-1:0] t_r;
  logic [7:0]           info_r;
  logic [PW-1:0]        cap;
  logic [AW-1:0]        head;
  logic [PW-1:0]        fill;
  logic [PW-1:0]        pos;
  logic [AW-1:0]        phys;
  stpq_res_t            res;

  logic [31:0]          t32;
  logic [TIME_BITS-1:0] t_in;
  logic [31:0]          cfg32;
  logic [PW-1:0]        cap_cfg;
  logic [PW:0]          tail_sum;
  logic [AW-1:0]        tail;
  logic [PW-1:0]        cap_m1;
  logic [AW-1:0]        prev;
  logic [TIME_BITS-1:0] rd_time;
  logic [31:0]          rd_time32;
  logic                 less;
  logic                 full;
  logic                 empty;
  logic [PW-1:0]        fill_inc;
  logic [PW-1:0]        fill_dec;
  logic [AW-1:0]        head_inc;

  function automatic logic [4:0] cnt5(input logic [PW-1:0] v);
    logic [31:0] w;
    w = 32'(v);
    return w[4:0];
  endfunction

  // Input key trimmed to the stored time width
  assign t32  = 32'(item.item_time);
  assign t_in = t32[TIME_BITS-1:0];

  // Clamp a capacity write into 1..DEPTH
  assign cfg32 = 32'(cfg_data);
  always_comb begin
    if (cfg32 == 32'd0) begin
      cap_cfg = PW'(1);
    end else if (cfg32 > DEPTH32) begin
      cap_cfg = PW'(DEPTH);
    end else begin
      cap_cfg = cfg32[PW-1:0];
    end
  end

  // Physical cell of the tail and the circular step toward the head
  assign tail_sum = (PW+1)'(head) + (PW+1)'(fill);
  assign tail     = (tail_sum >= (PW+1)'(cap)) ? AW'(tail_sum - (PW+1)'(cap))
                                               : AW'(tail_sum);
  assign cap_m1   = cap - PW'(1);
  assign prev     = (phys == '0) ? AW'(cap_m1) : phys - AW'(1);
  assign head_inc = ((PW'(head) + PW'(1)) == cap) ? '0 : head + AW'(1);

  // Shared compare on the entry read back
  assign rd_time   = mem_rdata[TIME_BITS+7:8];
  assign rd_time32 = 32'(rd_time);
  assign less      = t_r < rd_time;

  assign full     = fill >= cap;
  assign empty    = fill == '0;
  assign fill_inc = fill + PW'(1);
  assign fill_dec = fill - PW'(1);

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (start) begin
          if (item.cmd == CMD_ENQ) begin
            state_next = full ? S_RESP : S_WALK;
          end else begin
            state_next = empty ? S_RESP : S_DEQ;
          end
        end
      end
      S_WALK:  state_next = (pos == '0) ? S_RESP : S_CMP;
      S_CMP:   state_next = less ? S_WALK : S_RESP;
      S_DEQ:   state_next = S_RESP;
      S_RESP:  state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // Memory port and handshake outputs
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = phys;
    mem_wdata = {t_r, info_r};
    mem_raddr = head;
    case (state)
      S_WALK: begin
        mem_raddr = prev;
        mem_we    = (pos == '0);
      end
      S_CMP: begin
        mem_we = 1'b1;
        if (less) begin
          mem_wdata = mem_rdata;
        end
      end
      default: begin
        mem_raddr = head;
      end
    endcase
  end

  assign busy   = state != S_IDLE;
  assign done   = state == S_RESP;
  assign result = res;

  // Sequencer registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cap   <= CAP_RESET;
      head  <= '0;
      fill  <= '0;
    end else begin
      state <= state_next;
      case (state)
        S_IDLE: begin
          if (start) begin
            t_r    <= t_in;
            info_r <= item.item_info;
            pos    <= fill;
            phys   <= tail;
            res.out_time <= '0;
            res.out_info <= '0;
            res.count    <= cnt5(fill);
            res.status   <= (item.cmd == CMD_ENQ) ? STAT_FULL : STAT_EMPTY;
          end
        end
        S_WALK: begin
          // Reached the head: the new entry lands here
          if (pos == '0) begin
            fill       <= fill_inc;
            res.count  <= cnt5(fill_inc);
            res.status <= STAT_ENQ;
          end
        end
        S_CMP: begin
          if (less) begin
            phys <= prev;
            pos  <= pos - PW'(1);
          end else begin
            fill       <= fill_inc;
            res.count  <= cnt5(fill_inc);
            res.status <= STAT_ENQ;
          end
        end
        S_DEQ: begin
          res.out_time <= rd_time32[15:0];
          res.out_info <= mem_rdata[7:0];
          res.status   <= STAT_DEQ;
          res.count    <= cnt5(fill_dec);
          fill         <= fill_dec;
          head         <= (fill_dec == '0) ? '0 : head_inc;
        end
        default: begin
        end
      endcase
      // Capacity write empties the queue
      if (cfg_we) begin
        cap  <= cap_cfg;
        head <= '0;
        fill <= '0;
      end
    end
  end

endmodule
`default_nettype wire
